// ----- rtl/mevb_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mevb_pkg
// Types and constants shared by the event byte encoder modules.
// ----------------------------------------------------------------------------
package mevb_pkg;

    localparam int DELTA_W   = 28;
    localparam int GROUP_W   = 7;
    localparam int BYTE_W    = 8;
    localparam int KIND_W    = 4;
    localparam int CHAN_W    = 4;

    localparam logic [KIND_W-1:0] KIND_FIRST = 4'd8;   // note-off
    localparam logic [KIND_W-1:0] KIND_LAST  = 4'd14;  // pitch-bend
    localparam logic [BYTE_W-1:0] VLQ_CONT   = 8'h80;

    typedef struct packed {
        logic [DELTA_W-1:0] delta_ticks;
        logic [KIND_W-1:0]  event_kind;
        logic [BYTE_W-1:0]  first_param;
        logic [BYTE_W-1:0]  second_param;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last_byte;
    } t_out_item;

    // classified event, as queued between front and back
    typedef struct packed {
        logic [DELTA_W-1:0] delta;
        logic [1:0]         grp_last;   // index of most significant VLQ group
        logic [BYTE_W-1:0]  status;
        logic [BYTE_W-1:0]  p1;
        logic [BYTE_W-1:0]  p2;
        logic               has_p2;
    } t_desc;

endpackage
`default_nettype wire

// ----- rtl/midi_event_byte_encoder.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// midi_event_byte_encoder
// Encodes MIDI channel events into file bytes (VLQ delta, status, params).
// ----------------------------------------------------------------------------
// An event is taken and queued; the serializer then emits one byte per
// cycle while the output is not stalled: 1 to 4 delta bytes, the status
// byte, parameter 1 and, when nonzero, parameter 2. Input accepts back
// to back until the QUEUE_DEPTH-entry queue is full; events of
// unsupported kinds are dropped at the input and emit nothing. The output
// byte register sets the sustained rate of one byte per cycle while the
// output is not stalled. The channel register is sampled on acceptance.
module midi_event_byte_encoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [mevb_pkg::CHAN_W-1:0] i_cfg_data,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  mevb_pkg::t_in_item               i_in,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output mevb_pkg::t_out_item              o_out
);

    logic            push;
    logic            pop;
    logic            q_full;
    logic            q_empty;
    mevb_pkg::t_desc desc;
    mevb_pkg::t_desc head;

    mevb_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .i_in       (i_in),
        .i_q_full   (q_full),
        .o_in_stall (o_in_stall),
        .o_push     (push),
        .o_desc     (desc)
    );

    mevb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (desc),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head)
    );

    mevb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_head      (head),
        .o_pop       (pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule
`default_nettype wire

// ----- rtl/mevb_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mevb_front
// Accepts events, drops unsupported kinds, builds the queued descriptor.
// ----------------------------------------------------------------------------
module mevb_front (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [mevb_pkg::CHAN_W-1:0]    i_cfg_data,
    input  wire logic                           i_in_valid,
    input  mevb_pkg::t_in_item                  i_in,
    input  wire logic                           i_q_full,
    output logic                                o_in_stall,
    output logic                                o_push,
    output mevb_pkg::t_desc                     o_desc
);

    logic [mevb_pkg::CHAN_W-1:0] r_channel;
    logic                        kind_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel <= '0;
        end else if (i_cfg_we) begin
            r_channel <= i_cfg_data;
        end
    end

    always_comb begin
        kind_ok = (i_in.event_kind >= mevb_pkg::KIND_FIRST) &&
                  (i_in.event_kind <= mevb_pkg::KIND_LAST);
        o_in_stall = i_q_full;
        o_push     = i_in_valid && !i_q_full && kind_ok;

        o_desc.delta  = i_in.delta_ticks;
        o_desc.status = {i_in.event_kind, r_channel};
        o_desc.p1     = i_in.first_param;
        o_desc.p2     = i_in.second_param;
        o_desc.has_p2 = (i_in.second_param != '0);
        if (i_in.delta_ticks[27:21] != '0) begin
            o_desc.grp_last = 2'd3;
        end else if (i_in.delta_ticks[20:14] != '0) begin
            o_desc.grp_last = 2'd2;
        end else if (i_in.delta_ticks[13:7] != '0) begin
            o_desc.grp_last = 2'd1;
        end else begin
            o_desc.grp_last = 2'd0;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/mevb_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mevb_queue
// Small descriptor FIFO decoupling the classifier from the serializer.
// ----------------------------------------------------------------------------
module mevb_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    input  mevb_pkg::t_desc i_desc,
    input  wire logic       i_pop,
    output logic            o_full,
    output logic            o_empty,
    output mevb_pkg::t_desc o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mevb_pkg::t_desc   r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(DEPTH - 1)) begin
            return '0;
        end
        return p + PTR_W'(1);
    endfunction

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- rtl/mevb_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mevb_back
// Walks the head descriptor one byte per cycle, unless the output stalls, into the output register.
// ----------------------------------------------------------------------------
module mevb_back (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_q_empty,
    input  mevb_pkg::t_desc   i_head,
    output logic              o_pop,
    input  wire logic         i_out_stall,
    output logic              o_out_valid,
    output mevb_pkg::t_out_item o_out
);

    logic [2:0]                  r_idx;
    logic                        r_out_vld;
    mevb_pkg::t_out_item         r_out;
    mevb_pkg::t_out_item         n_out;

    logic [2:0]                  gl_ext;
    logic [2:0]                  last_idx;
    logic [1:0]                  grp;
    logic [mevb_pkg::GROUP_W-1:0] grp_bits;
    logic                        load_en;
    logic                        advance;

    always_comb begin
        gl_ext   = {1'b0, i_head.grp_last};
        last_idx = gl_ext + 3'd2 + {2'b00, i_head.has_p2};
        grp      = i_head.grp_last - r_idx[1:0];
        unique case (grp)
            2'd0: grp_bits = i_head.delta[6:0];
            2'd1: grp_bits = i_head.delta[13:7];
            2'd2: grp_bits = i_head.delta[20:14];
            2'd3: grp_bits = i_head.delta[27:21];
            default: grp_bits = '0;
        endcase

        if (r_idx <= gl_ext) begin
            n_out.out_byte = {1'b0, grp_bits} |
                             ((r_idx != gl_ext) ? mevb_pkg::VLQ_CONT : '0);
        end else if (r_idx == gl_ext + 3'd1) begin
            n_out.out_byte = i_head.status;
        end else if (r_idx == gl_ext + 3'd2) begin
            n_out.out_byte = i_head.p1;
        end else begin
            n_out.out_byte = i_head.p2;
        end
        n_out.last_byte = (r_idx == last_idx);

        load_en = !r_out_vld || !i_out_stall;
        advance = !i_q_empty && load_en;
        o_pop   = advance && n_out.last_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (advance) begin
                r_idx <= n_out.last_byte ? 3'd0 : r_idx + 3'd1;
            end
            if (load_en) begin
                r_out_vld <= !i_q_empty;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

endmodule
`default_nettype wire

// ----- bench/mevb_byte_checker.sv -----
// ----------------------------------------------------------------------------
// mevb_byte_checker
// Watches the event request and byte channels of the event byte encoder,
// predicts the file bytes of every accepted event and compares each
// accepted byte, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module mevb_byte_checker
    import mevb_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [CHAN_W-1:0] i_cfg_data,
    input  wire logic              i_in_valid,
    input  wire logic              i_in_stall,
    input  t_in_item               i_in,
    input  wire logic              i_out_valid,
    input  wire logic              i_out_stall,
    input  t_out_item              i_out,
    output int                     o_fail_count,
    output int                     o_pending,
    output int                     o_events,
    output int                     o_dropped,
    output int                     o_bytes
);

    localparam int PRINT_CAP = 30;

    t_out_item         expected_bytes[$];
    logic [CHAN_W-1:0] chan_shadow = '0;
    int                fail_count  = 0;
    int                event_count = 0;
    int                drop_count  = 0;
    int                byte_count  = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_events     = 0;
        o_dropped    = 0;
        o_bytes      = 0;
    end

    task automatic report_mismatch(input string what);
        if (fail_count < PRINT_CAP)
            $display("[%0t] mismatch: %s", $realtime, what);
        fail_count++;
    endtask

    // VLQ delta, status, param 1, param 2 when nonzero; last flag on the tail
    function automatic void predict_event_bytes(input t_in_item ev);
        t_out_item          seq[$];
        t_out_item          r;
        logic [DELTA_W-1:0] part;
        int                 groups;
        int                 g;
        if (ev.event_kind < KIND_FIRST || ev.event_kind > KIND_LAST) begin
            drop_count++;
            return;
        end
        groups = 1;
        while (groups < 4 && (ev.delta_ticks >> (GROUP_W * groups)) != 0)
            groups++;
        for (g = groups; g > 0; g--) begin
            part = ev.delta_ticks >> (GROUP_W * (g - 1));
            r.out_byte = {1'b0, part[GROUP_W-1:0]};
            if (g != 1)
                r.out_byte = r.out_byte | VLQ_CONT;
            r.last_byte = 1'b0;
            seq.push_back(r);
        end
        r.out_byte  = {ev.event_kind, chan_shadow};
        r.last_byte = 1'b0;
        seq.push_back(r);
        r.out_byte = ev.first_param;
        seq.push_back(r);
        if (ev.second_param != '0) begin
            r.out_byte = ev.second_param;
            seq.push_back(r);
        end
        seq[seq.size()-1].last_byte = 1'b1;
        foreach (seq[k])
            expected_bytes.push_back(seq[k]);
        event_count++;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            chan_shadow = '0;
            expected_bytes.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_bytes.size() == 0) begin
                    report_mismatch($sformatf("unexpected byte %02h last=%0b",
                                              i_out.out_byte, i_out.last_byte));
                end else begin
                    want = expected_bytes.pop_front();
                    if (i_out.out_byte !== want.out_byte)
                        report_mismatch($sformatf("out_byte %02h, expected %02h",
                                                  i_out.out_byte, want.out_byte));
                    if (i_out.last_byte !== want.last_byte)
                        report_mismatch($sformatf("last_byte %0b on %02h, expected %0b",
                                                  i_out.last_byte, want.out_byte,
                                                  want.last_byte));
                end
                byte_count++;
            end
            // channel is sampled at request time, so a same-edge write lands after
            if (i_in_valid && !i_in_stall)
                predict_event_bytes(i_in);
            if (i_cfg_we)
                chan_shadow = i_cfg_data;
        end
        o_fail_count <= fail_count;
        o_pending    <= expected_bytes.size();
        o_events     <= event_count;
        o_dropped    <= drop_count;
        o_bytes      <= byte_count;
    end

endmodule

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives MIDI channel events into the event byte encoder under random gaps
// and output stalls, across several channel settings, and lets the checker
// verify every emitted byte.
// ----------------------------------------------------------------------------
module testbench;
    import mevb_pkg::*;

    localparam int RAND_ITEMS  = 90;
    localparam int HOLD_CYCLES = 200;
    localparam int SETTLE      = 8;
    localparam int DRAIN_LIMIT = 20000;

    logic              i_clk      = 1'b0;
    logic              i_rst_n    = 1'b0;
    logic              i_cfg_we   = 1'b0;
    logic [CHAN_W-1:0] i_cfg_data = '0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    t_in_item          i_in       = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    t_out_item         o_out;

    int fail_count;
    int pending;
    int events_seen;
    int dropped_seen;
    int bytes_seen;

    bit quiet    = 1'b0;   // no idling on either side
    bit hold_req = 1'b0;   // receiver holds off for a long stretch
    int sent     = 0;
    int chan_mid;

    midi_event_byte_encoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    mevb_byte_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in         (i_in),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out        (o_out),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_events     (events_seen),
        .o_dropped    (dropped_seen),
        .o_bytes      (bytes_seen)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d bytes outstanding", pending);
        $display("== FAIL ==");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 8);
        return $urandom_range(10, 30);
    endfunction

    // receiver stall pattern
    initial begin
        int run;
        bit stalled;
        run     = 0;
        stalled = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
                hold_req = 1'b0;
                stalled  = 1'b0;
                run      = 0;
            end else begin
                if (run == 0) begin
                    if (stalled) begin
                        stalled = 1'b0;
                        run     = $urandom_range(1, 24);
                    end else begin
                        run     = pick_gap();
                        stalled = (run != 0);
                        if (run == 0)
                            run = $urandom_range(1, 24);
                    end
                end
                i_out_stall <= stalled && !quiet;
                run--;
            end
        end
    end

    function automatic t_in_item make_event(input logic [DELTA_W-1:0] delta,
                                            input logic [KIND_W-1:0] kind,
                                            input logic [BYTE_W-1:0] p1,
                                            input logic [BYTE_W-1:0] p2);
        t_in_item ev;
        ev.delta_ticks  = delta;
        ev.event_kind   = kind;
        ev.first_param  = p1;
        ev.second_param = p2;
        return ev;
    endfunction

    function automatic t_in_item random_event();
        logic [DELTA_W-1:0] delta;
        logic [KIND_W-1:0]  kind;
        logic [BYTE_W-1:0]  p2;
        case ($urandom_range(0, 5))
            0: delta = '0;
            1: delta = DELTA_W'($urandom_range(1, 127));
            2: delta = DELTA_W'($urandom_range(128, 16383));
            3: delta = DELTA_W'($urandom_range(16384, 2097151));
            4: delta = DELTA_W'($urandom_range(2097152, 28'hFFFFFFF));
            default: delta = DELTA_W'($urandom());
        endcase
        if ($urandom_range(0, 99) < 85)
            kind = KIND_W'($urandom_range(KIND_FIRST, KIND_LAST));
        else begin
            kind = KIND_W'($urandom_range(0, 8));
            if (kind == 4'd8)
                kind = 4'd15;
        end
        p2 = ($urandom_range(0, 3) == 0) ? 8'h00 : BYTE_W'($urandom_range(0, 255));
        return make_event(delta, kind, BYTE_W'($urandom_range(0, 255)), p2);
    endfunction

    // returns in the step of acceptance with valid still high
    task automatic push_event(input t_in_item ev);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in       <= ev;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sent++;
    endtask

    task automatic wait_idle();
        int waited;
        waited = 0;
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_channel(input logic [CHAN_W-1:0] chan);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= chan;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic random_events(input int count);
        int target;
        target = sent + count;
        while (sent < target)
            push_event(random_event());
    endtask

    initial begin
        t_in_item directed[$];

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // delta group boundaries, every kind, param edge values; channel at reset 0
        directed.push_back(make_event(28'd0,         4'd8,  8'h00, 8'h00));
        directed.push_back(make_event(28'd127,       4'd9,  8'hFF, 8'hFF));
        directed.push_back(make_event(28'd128,       4'd10, 8'h55, 8'h00));
        directed.push_back(make_event(28'd16383,     4'd11, 8'hAA, 8'h01));
        directed.push_back(make_event(28'd16384,     4'd12, 8'h7F, 8'h80));
        directed.push_back(make_event(28'd2097151,   4'd13, 8'h01, 8'h00));
        directed.push_back(make_event(28'd2097152,   4'd14, 8'h80, 8'h7F));
        directed.push_back(make_event(28'hFFFFFFF,   4'd8,  8'hFF, 8'hFF));
        directed.push_back(make_event(28'h5555555,   4'd14, 8'h00, 8'hAA));
        directed.push_back(make_event(28'hAAAAAAA,   4'd11, 8'hFF, 8'h55));
        for (int k = 0; k < 8; k++)
            directed.push_back(make_event(28'hFFFFFFF >> (k * 3), k[KIND_W-1:0],
                                          8'hFF, 8'hFF));
        directed.push_back(make_event(28'd0,         4'd15, 8'h12, 8'h00));
        directed.push_back(make_event(28'd1,         4'd12, 8'h00, 8'h00));
        foreach (directed[k])
            push_event(directed[k]);
        wait_idle();

        write_channel(4'd15);
        quiet = 1'b1;
        random_events(15);
        quiet = 1'b0;
        random_events(25);
        wait_idle();

        // receiver holds off while the sender keeps pushing
        write_channel(4'd0);
        hold_req = 1'b1;
        random_events(25);
        wait_idle();

        chan_mid = $urandom_range(1, 14);
        write_channel(chan_mid[CHAN_W-1:0]);
        random_events(RAND_ITEMS - 65);
        wait_idle();

        $display("covered %0d encoded events and %0d dropped kinds, %0d bytes checked",
                 events_seen, dropped_seen, bytes_seen);
        $display("channels 0, 15 and %0d, random gaps and stalls, one long output hold-off",
                 chan_mid);
        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
